// ===== src/slme_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list merge engine package
// Shared constants, types and helper functions for the merge engine.
// ----------------------------------------------------------------------------
package slme_pkg;

  localparam int LIST_DEPTH    = 32;
  localparam int ELEMENT_WIDTH = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int COUNT_W = $clog2(2 * LIST_DEPTH + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W   = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [CMP_W-1:0]         cmp_t;
  typedef logic signed [31:0]              word_t;

  typedef enum logic [1:0] {
    OP_INS_A = 2'd0,
    OP_INS_B = 2'd1,
    OP_MERGE = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_MERGE = 1'b1
  } state_t;

  typedef struct packed {
    opcode_t op;
    elem_t   value;
    word_t   query;
  } cmd_t;

  function automatic logic elem_matches(elem_t e, word_t q);
    return cmp_t'(e) == cmp_t'(q);
  endfunction

  function automatic word_t elem_to_word(elem_t e);
    return word_t'(e);
  endfunction

endpackage

// ===== src/slme_front.sv =====
// ----------------------------------------------------------------------------
// Sorted list merge engine front end
// Accepts input beats, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module slme_front
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] value,
  input  logic signed [31:0] query_value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  cmd_t              in_cmd;
  logic              push;

  always_comb begin
    in_cmd.op    = opcode_t'(opcode);
    in_cmd.value = elem_t'(value);
    in_cmd.query = query_value;
  end

  assign in_stall  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== src/slme_back.sv =====
// ----------------------------------------------------------------------------
// Sorted list merge engine back end
// Holds both lists, performs sorted inserts, clears and merges, and drives
// the output register.
// ----------------------------------------------------------------------------
module slme_back
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] element,
  output logic        first_of_run,
  output logic [6:0]  match_count,
  output logic [1:0]  status,
  output logic        last
);

  elem_t            list_a [LIST_DEPTH];
  elem_t            list_b [LIST_DEPTH];
  elem_t            ins_row [LIST_DEPTH];
  elem_t            new_row [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] lt;
  logic [CNT_W-1:0] ins_len;

  state_t           state, state_next;
  logic [CNT_W-1:0] len_a, len_a_next;
  logic [CNT_W-1:0] len_b, len_b_next;
  logic [CNT_W-1:0] ia, ia_next;
  logic [CNT_W-1:0] ib, ib_next;
  logic [COUNT_W-1:0] count, count_next;
  elem_t            prev, prev_next;
  logic             have_prev, have_prev_next;
  word_t            query, query_next;
  logic             write_a, write_b;

  logic             out_valid_next;
  word_t            element_next;
  logic             first_of_run_next;
  logic [6:0]       match_count_next;
  logic [1:0]       status_next;
  logic             last_next;

  logic             load;
  logic             a_avail, b_avail, take_a;
  elem_t            a_e, b_e, e;
  logic [CNT_W-1:0] ia_step, ib_step;
  logic [COUNT_W-1:0] count_step;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ins_row[i] = (cmd.op == OP_INS_A) ? list_a[i] : list_b[i];
    end
    ins_len = (cmd.op == OP_INS_A) ? len_a : len_b;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < ins_len) && (ins_row[i] < cmd.value);
    end
    new_row[0] = lt[0] ? ins_row[0] : cmd.value;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      if (lt[i]) begin
        new_row[i] = ins_row[i];
      end else if (lt[i-1]) begin
        new_row[i] = cmd.value;
      end else begin
        new_row[i] = ins_row[i-1];
      end
    end
  end

  always_comb begin
    a_avail    = (ia < len_a);
    b_avail    = (ib < len_b);
    a_e        = list_a[a_avail ? ia[IDX_W-1:0] : '0];
    b_e        = list_b[b_avail ? ib[IDX_W-1:0] : '0];
    take_a     = a_avail && (!b_avail || (a_e <= b_e));
    e          = take_a ? a_e : b_e;
    ia_step    = ia + CNT_W'(take_a);
    ib_step    = ib + CNT_W'(!take_a);
    count_step = count + COUNT_W'(elem_matches(e, query));
  end

  assign load = !out_valid || !out_stall;

  always_comb begin
    state_next        = state;
    len_a_next        = len_a;
    len_b_next        = len_b;
    ia_next           = ia;
    ib_next           = ib;
    count_next        = count;
    prev_next         = prev;
    have_prev_next    = have_prev;
    query_next        = query;
    write_a           = 1'b0;
    write_b           = 1'b0;
    cmd_pop           = 1'b0;
    out_valid_next    = load ? 1'b0 : out_valid;
    element_next      = element;
    first_of_run_next = first_of_run;
    match_count_next  = match_count;
    status_next       = status;
    last_next         = last;

    case (state)
      S_IDLE: begin
        if (cmd_valid && load) begin
          cmd_pop           = 1'b1;
          element_next      = '0;
          first_of_run_next = 1'b0;
          match_count_next  = '0;
          status_next       = ST_OK;
          last_next         = 1'b1;
          out_valid_next    = 1'b1;
          case (cmd.op)
            OP_INS_A: begin
              if (len_a == CNT_W'(LIST_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                write_a    = 1'b1;
                len_a_next = len_a + CNT_W'(1);
              end
            end
            OP_INS_B: begin
              if (len_b == CNT_W'(LIST_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                write_b    = 1'b1;
                len_b_next = len_b + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              len_a_next = '0;
              len_b_next = '0;
            end
            OP_MERGE: begin
              if ((len_a == '0) && (len_b == '0)) begin
                status_next = ST_EMPTY;
              end else begin
                out_valid_next = 1'b0;
                query_next     = cmd.query;
                ia_next        = '0;
                ib_next        = '0;
                count_next     = '0;
                have_prev_next = 1'b0;
                state_next     = S_MERGE;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_MERGE: begin
        if (load) begin
          out_valid_next    = 1'b1;
          element_next      = elem_to_word(e);
          first_of_run_next = !have_prev || (e != prev);
          status_next       = ST_OK;
          have_prev_next    = 1'b1;
          prev_next         = e;
          ia_next           = ia_step;
          ib_next           = ib_step;
          count_next        = count_step;
          if ((ia_step == len_a) && (ib_step == len_b)) begin
            last_next        = 1'b1;
            match_count_next = 7'(count_step);
            state_next       = S_IDLE;
          end else begin
            last_next        = 1'b0;
            match_count_next = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len_a     <= '0;
      len_b     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len_a     <= len_a_next;
      len_b     <= len_b_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ia           <= ia_next;
    ib           <= ib_next;
    count        <= count_next;
    prev         <= prev_next;
    have_prev    <= have_prev_next;
    query        <= query_next;
    element      <= element_next;
    first_of_run <= first_of_run_next;
    match_count  <= match_count_next;
    status       <= status_next;
    last         <= last_next;
    if (write_a) begin
      list_a <= new_row;
    end
    if (write_b) begin
      list_b <= new_row;
    end
  end

endmodule

// ===== src/sorted_list_merge_engine_top.sv =====
// ----------------------------------------------------------------------------
// Sorted list merge engine
// An accepted input beat is registered in the command queue; the back end pops
// it when idle and registers its result beat in the output register.
// Insert, clear and empty merge: one result beat each. Merge: a start step
// with no beat, then len_a + len_b element beats, one per cycle unless stalled.
// Reset clears list lengths, the command queue and the output valid flag;
// list contents are not cleared and are only read below the list length.
// ----------------------------------------------------------------------------
module sorted_list_merge_engine_top
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] value,
  input  logic signed [31:0] query_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] element,
  output logic        first_of_run,
  output logic [6:0]  match_count,
  output logic [1:0]  status,
  output logic        last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  slme_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .value       (value),
    .query_value (query_value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  slme_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .element      (element),
    .first_of_run (first_of_run),
    .match_count  (match_count),
    .status       (status),
    .last         (last)
  );

endmodule

// ===== bench/list_merge_tracker_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list merge tracker
// Keeps a shadow copy of both sorted lists, works out the result beats that
// each accepted command causes and checks the beats that the engine emits.
// ----------------------------------------------------------------------------
package list_merge_tracker_pkg;

  import slme_pkg::*;

  typedef struct {
    word_t      element;
    logic       first_of_run;
    logic [6:0] match_count;
    status_t    status;
    logic       last;
  } merge_beat_t;

  class list_merge_tracker;
    elem_t       list_a[LIST_DEPTH];
    elem_t       list_b[LIST_DEPTH];
    int unsigned len_a;
    int unsigned len_b;
    merge_beat_t pending_beats[$];
    int unsigned error_count;
    int unsigned beats_checked;
    int unsigned merges_seen;
    int unsigned drops_seen;

    function new();
      len_a         = 0;
      len_b         = 0;
      error_count   = 0;
      beats_checked = 0;
      merges_seen   = 0;
      drops_seen    = 0;
    endfunction

    function int unsigned pending();
      return pending_beats.size();
    endfunction

    function void push_status(status_t st);
      merge_beat_t beat;
      beat.element      = '0;
      beat.first_of_run = 1'b0;
      beat.match_count  = '0;
      beat.status       = st;
      beat.last         = 1'b1;
      pending_beats.push_back(beat);
    endfunction

    function status_t insert_sorted(bit to_b, elem_t x);
      elem_t       row[LIST_DEPTH];
      int unsigned n;
      int unsigned pos;
      if (to_b) begin
        row = list_b;
        n   = len_b;
      end else begin
        row = list_a;
        n   = len_a;
      end
      if (n >= LIST_DEPTH) return ST_FULL;
      pos = 0;
      while (pos < n && row[pos] < x) pos++;
      for (int unsigned i = n; i > pos; i--) row[i] = row[i-1];
      row[pos] = x;
      if (to_b) begin
        list_b = row;
        len_b  = n + 1;
      end else begin
        list_a = row;
        len_a  = n + 1;
      end
      return ST_OK;
    endfunction

    function void expand_merge(word_t qry);
      int unsigned ia;
      int unsigned ib;
      int unsigned count;
      elem_t       e;
      elem_t       prev;
      bit          have_prev;
      bit          take_a;
      merge_beat_t beat;
      if (len_a + len_b == 0) begin
        push_status(ST_EMPTY);
        return;
      end
      merges_seen++;
      ia        = 0;
      ib        = 0;
      count     = 0;
      have_prev = 1'b0;
      prev      = '0;
      while (ia < len_a || ib < len_b) begin
        take_a = (ia < len_a) && (ib >= len_b || list_a[ia] <= list_b[ib]);
        if (take_a) begin
          e = list_a[ia];
          ia++;
        end else begin
          e = list_b[ib];
          ib++;
        end
        beat.first_of_run = !have_prev || (e != prev);
        have_prev = 1'b1;
        prev      = e;
        if (longint'(e) == longint'(qry)) count++;
        beat.element     = word_t'(e);
        beat.last        = (ia >= len_a) && (ib >= len_b);
        beat.match_count = beat.last ? 7'(count) : 7'd0;
        beat.status      = ST_OK;
        pending_beats.push_back(beat);
      end
    endfunction

    function void note_command(opcode_t op, word_t val, word_t qry);
      status_t st;
      case (op)
        OP_INS_A, OP_INS_B: begin
          st = insert_sorted(op == OP_INS_B, elem_t'(val));
          if (st == ST_FULL) drops_seen++;
          push_status(st);
        end
        OP_CLEAR: begin
          len_a = 0;
          len_b = 0;
          push_status(ST_OK);
        end
        default: expand_merge(qry);
      endcase
    endfunction

    function void check_beat(word_t element, logic first_of_run, logic [6:0] match_count,
                             logic [1:0] status, logic last);
      merge_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: element %0d, status %0d", element, status);
        error_count++;
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (element !== want.element) begin
        $error("element: expected %0d, actual %0d", want.element, element);
        error_count++;
      end
      if (first_of_run !== want.first_of_run) begin
        $error("first_of_run: expected %0d, actual %0d", want.first_of_run, first_of_run);
        error_count++;
      end
      if (match_count !== want.match_count) begin
        $error("match_count: expected %0d, actual %0d", want.match_count, match_count);
        error_count++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        error_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list merge engine testbench
// Drives insert, merge and clear commands with random idling on the input
// and random stalls on the output, and checks every result beat against a
// shadow model of the two sorted lists.
// ----------------------------------------------------------------------------
module tb_top
  import slme_pkg::*, list_merge_tracker_pkg::*;
();

  localparam int unsigned STOP_AFTER   = 295;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        opcode;
  logic signed [31:0] value;
  logic signed [31:0] query_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [31:0] element;
  logic              first_of_run;
  logic [6:0]        match_count;
  logic [1:0]        status;
  logic              last;

  list_merge_tracker tracker = new();

  int unsigned commands_sent  = 0;
  int unsigned send_idle_pct  = 31;
  int unsigned recv_stall_pct = 31;
  bit          hold_start     = 1'b0;
  bit          hold_taken     = 1'b0;
  int unsigned hold_left      = 0;
  word_t       recent_value   = '0;

  sorted_list_merge_engine_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .value        (value),
    .query_value  (query_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .element      (element),
    .first_of_run (first_of_run),
    .match_count  (match_count),
    .status       (status),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_beat(element, first_of_run, match_count, status, last);
    end
  end

  function automatic word_t pick_value();
    int unsigned sel;
    word_t       v;
    sel = $urandom_range(99);
    if (sel < 35) begin
      v = word_t'(int'($urandom_range(6)) - 3);
    end else if (sel < 45) begin
      case ($urandom_range(3))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7FFF_FFFF;
        2:       v = '0;
        default: v = -32'sd1;
      endcase
    end else begin
      v = word_t'($urandom);
    end
    recent_value = v;
    return v;
  endfunction

  function automatic word_t pick_query();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return recent_value;
    if (sel < 70) return word_t'(int'($urandom_range(6)) - 3);
    return pick_value();
  endfunction

  task automatic send_command(input opcode_t op, input word_t val, input word_t qry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    value       <= val;
    query_value <= qry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(op, val, qry);
    commands_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_list_sequence(input int unsigned fill_a, input int unsigned fill_b,
                                   input bit hold_output);
    int unsigned na;
    int unsigned nb;
    na = fill_a;
    nb = fill_b;
    send_command(OP_CLEAR, pick_value(), pick_value());
    while (na + nb > 0) begin
      if (nb == 0 || (na != 0 && $urandom_range(1) == 0)) begin
        send_command(OP_INS_A, pick_value(), word_t'($urandom));
        na--;
      end else begin
        send_command(OP_INS_B, pick_value(), word_t'($urandom));
        nb--;
      end
    end
    if (hold_output) hold_start = 1'b1;
    repeat ($urandom_range(1, 2)) send_command(OP_MERGE, word_t'($urandom), pick_query());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_command(opcode_t'($urandom_range(3)), pick_value(), pick_query());
    end
  endtask

  initial begin
    int unsigned seq_idx;
    int unsigned fa;
    int unsigned fb;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_INS_A;
    value       = '0;
    query_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_command(OP_MERGE, '0, '0);
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_INS_A, 32'sh7FFF_FFFF, '0);
    send_command(OP_INS_A, 32'sh8000_0000, '0);
    send_command(OP_INS_A, '0, '0);
    send_command(OP_INS_A, -32'sd1, '0);
    send_command(OP_INS_A, '0, '0);
    send_command(OP_INS_B, '0, '0);
    send_command(OP_INS_B, 32'sh8000_0000, '0);
    send_command(OP_INS_B, 32'sh7FFF_FFFF, '0);
    send_command(OP_INS_B, 32'sd5, '0);
    send_command(OP_MERGE, '1, '0);
    send_command(OP_MERGE, '0, 32'sh8000_0000);
    send_command(OP_MERGE, '0, 32'sh7FFF_FFFF);
    send_command(OP_MERGE, '0, 32'sd12345);
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_INS_B, 32'sd7, '0);
    send_command(OP_MERGE, '0, 32'sd7);
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_INS_A, -32'sd7, '0);
    send_command(OP_MERGE, '0, -32'sd7);
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_MERGE, '0, '0);
    wait_drained();

    seq_idx = 0;
    while (commands_sent < STOP_AFTER) begin
      if (seq_idx == 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (seq_idx == 9) begin
        send_idle_pct  = 31;
        recv_stall_pct = 31;
      end
      if (seq_idx == 10) wait_drained();
      if (seq_idx == 0) begin
        run_list_sequence(LIST_DEPTH + 1, LIST_DEPTH + 2, 1'b1);
      end else if ($urandom_range(99) < 75) begin
        fa = ($urandom_range(99) < 6) ? LIST_DEPTH + 1 : $urandom_range(0, 6);
        fb = ($urandom_range(99) < 6) ? LIST_DEPTH + 1 : $urandom_range(0, 6);
        run_list_sequence(fa, fb, 1'b0);
      end else begin
        send_noise();
      end
      seq_idx++;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d non-empty merges, %0d inserts dropped on a full list",
             commands_sent, tracker.merges_seen, tracker.drops_seen);
    $display("checked %0d result beats, %0d mismatches",
             tracker.beats_checked, tracker.error_count);
    if (tracker.error_count == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sorted_list_merge_engine_top.f =====
src/slme_pkg.sv
src/slme_front.sv
src/slme_back.sv
src/sorted_list_merge_engine_top.sv
bench/list_merge_tracker_pkg.sv
bench/tb_top.sv
